// ===== src/ktg_pkg.sv =====
// Shared types, key codes and the note frequency table for the keypad tone generator.
// No dependencies; the controller, datapath and top level use it.
package ktg_pkg;

    localparam int unsigned FREQ_W      = 12;
    localparam int unsigned HALF_W      = 10;
    localparam int unsigned CODE_W      = 5;
    localparam int unsigned OCT_W       = 3;
    localparam int unsigned KEYS_W      = 16;
    // divisor holds frequency times the sample count (two), below 8192
    localparam int unsigned DIVISOR_W   = 13;
    localparam int unsigned WAVE_SHIFT  = 1;

    localparam logic [HALF_W-1:0] HALF_MAX     = 10'd1023;
    localparam logic [FREQ_W-1:0] FREQ_RST     = 12'd440;
    localparam logic [OCT_W-1:0]  OCT_RST      = 3'd3;
    localparam logic [7:0]        DAC_HIGH     = 8'd255;
    localparam logic [7:0]        DAC_LOW      = 8'd0;

    localparam logic [CODE_W-1:0] KEY_NONE       = 5'd0;
    localparam logic [CODE_W-1:0] KEY_NOTE_FIRST = 5'd1;
    localparam logic [CODE_W-1:0] KEY_NOTE_LAST  = 5'd7;
    localparam logic [CODE_W-1:0] KEY_OCT_FIRST  = 5'd10;
    localparam logic [CODE_W-1:0] KEY_OCT_LAST   = 5'd16;

    localparam int unsigned NOTE_COUNT = 7;
    localparam int unsigned OCT_COUNT  = 7;

    // floor(base * 2^shift), rows C D E F G A H, columns octave shift 0..6
    localparam logic [FREQ_W-1:0] NOTE_FREQ [NOTE_COUNT][OCT_COUNT] = '{
        '{12'd32, 12'd65,  12'd130, 12'd261, 12'd523, 12'd1046, 12'd2093},
        '{12'd36, 12'd73,  12'd146, 12'd293, 12'd587, 12'd1174, 12'd2349},
        '{12'd41, 12'd82,  12'd164, 12'd329, 12'd659, 12'd1318, 12'd2637},
        '{12'd43, 12'd87,  12'd174, 12'd349, 12'd698, 12'd1396, 12'd2793},
        '{12'd48, 12'd97,  12'd195, 12'd391, 12'd783, 12'd1567, 12'd3135},
        '{12'd55, 12'd110, 12'd220, 12'd440, 12'd880, 12'd1760, 12'd3520},
        '{12'd61, 12'd123, 12'd246, 12'd493, 12'd987, 12'd1975, 12'd3951}
    };

    // controller to datapath
    typedef struct packed {
        logic apply;     // accepted item, update state
        logic div_step;  // one divider iteration
        logic load_out;  // capture result into output register
    } t_ktg_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;  // scan decodes a new note key
        logic div_last;  // current iteration is the final one
    } t_ktg_stat;

    function automatic logic [FREQ_W-1:0] note_freq(
        input logic [2:0] note,
        input logic [OCT_W-1:0] shift
    );
        logic [FREQ_W-1:0] f;
        f = '0;
        if (note < 3'(NOTE_COUNT) && shift < 3'(OCT_COUNT)) begin
            f = NOTE_FREQ[note][shift];
        end
        return f;
    endfunction

endpackage

// ===== src/keypad_square_tone_generator_core.sv =====
// Channel   Dir  Handshake             Payload
// s         in   i_s_tvalid/o_s_tready tdata = keys, tuser = command
// m         out  o_m_tvalid/i_m_tready tdata = dac, note, octave, sounding
//
// Ticks, scans that keep the decoded key and scans of a non-note key load the
// output register on acceptance. A scan that decodes a new note key runs the
// restoring half-period divider for clog2(TICK_RATE+1) steps, one quotient
// bit per cycle. Reset is synchronous, active low, and needs no clearing time.
// The output register holds one item; a new item is taken while it is drained.
//
// Top level of the keypad tone generator; depends on ktg_pkg, ktg_ctrl and
// ktg_datapath.
module keypad_square_tone_generator_core #(
    parameter int unsigned TICK_RATE = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] keys
    input  logic [0:0]  i_s_tuser,   // [0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [7:0] dac_sample, [10:8] note_index,
                                     // [13:11] octave_number, [14] sounding, [15] zero
);

    ktg_pkg::t_ktg_cmd  cmd;
    ktg_pkg::t_ktg_stat stat;

    logic [7:0]                dac_sample;
    logic [2:0]                note_index;
    logic [ktg_pkg::OCT_W-1:0] octave_number;
    logic                      sounding;

    ktg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ktg_datapath #(
        .TICK_RATE (TICK_RATE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_s_tuser[0]),
        .i_keys          (i_s_tdata),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_dac_sample    (dac_sample),
        .o_note_index    (note_index),
        .o_octave_number (octave_number),
        .o_sounding      (sounding)
    );

    assign o_m_tdata = {1'b0, sounding, octave_number, note_index, dac_sample};

    // no item taken while the divider runs
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !o_s_tready)
        else $error("item accepted during divide");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("output overwritten before taken");

    // a decoded note and the tone being on go together
    a_note_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[10:8] != 3'd0) == o_m_tdata[14]))
        else $error("note index and sounding disagree");

    // DAC high only while sounding
    a_dac_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[7:0] != 8'd0)) |-> o_m_tdata[14])
        else $error("DAC high while silent");

endmodule

// ===== src/ktg_ctrl.sv =====
// Controller for the keypad tone generator: accept, divide and output handshake.
// Depends on ktg_pkg for the command and status structs.
module ktg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  ktg_pkg::t_ktg_stat i_stat,
    output ktg_pkg::t_ktg_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_s_tready       = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
        o_cmd.apply      = o_s_tready && i_s_tvalid;
        o_cmd.div_step   = (r_state == ST_DIV);
        o_cmd.load_out   = (o_cmd.apply && !i_stat.need_div) ||
                           (o_cmd.div_step && i_stat.div_last);
    end

    assign o_m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.apply && i_stat.need_div) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/ktg_datapath.sv =====
// Datapath for the keypad tone generator: key decode, tone state, period divider
// and output register. Depends on ktg_pkg; driven by ktg_ctrl commands.
module ktg_datapath #(
    parameter int unsigned TICK_RATE = 32768
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_command,
    input  logic [ktg_pkg::KEYS_W-1:0]  i_keys,
    input  ktg_pkg::t_ktg_cmd           i_cmd,
    output ktg_pkg::t_ktg_stat          o_stat,
    output logic [7:0]                  o_dac_sample,
    output logic [2:0]                  o_note_index,
    output logic [ktg_pkg::OCT_W-1:0]   o_octave_number,
    output logic                        o_sounding
);

    localparam int unsigned TW = $clog2(TICK_RATE + 1);
    localparam int unsigned CW = $clog2(TW);
    localparam logic [TW-1:0] DIVIDEND = TW'(TICK_RATE);
    localparam int unsigned HP_RST_Q = TICK_RATE / (440 * 2);
    localparam logic [ktg_pkg::HALF_W-1:0] HALF_RST =
        (HP_RST_Q > 1023) ? ktg_pkg::HALF_MAX : ktg_pkg::HALF_W'(HP_RST_Q);

    localparam int unsigned FW = ktg_pkg::FREQ_W;
    localparam int unsigned HW = ktg_pkg::HALF_W;
    localparam int unsigned DW = ktg_pkg::DIVISOR_W;

    logic [ktg_pkg::OCT_W-1:0]  r_oct,  n_oct;
    logic [FW-1:0]              r_freq, n_freq;
    logic [HW-1:0]              r_half, n_half;
    logic [HW-1:0]              r_tick, n_tick;
    logic                       r_phase, n_phase;
    logic                       r_tone_on, n_tone_on;
    logic [ktg_pkg::CODE_W-1:0] r_last, n_last;

    logic [DW-1:0] r_divisor, n_divisor;
    logic [DW-1:0] r_rem, n_rem;
    logic [TW-1:0] r_quo, n_quo;
    logic [TW-1:0] r_dvd, n_dvd;
    logic [CW-1:0] r_cnt, n_cnt;

    logic [ktg_pkg::CODE_W-1:0] code;
    logic                       is_note, is_oct;
    logic [HW-1:0]              tick_inc;
    logic [DW:0]                rem_sh;
    logic                       ge;

    // lowest pressed key wins
    always_comb begin
        code = ktg_pkg::KEY_NONE;
        for (int i = ktg_pkg::KEYS_W - 1; i >= 0; i--) begin
            if (i_keys[i]) begin
                code = ktg_pkg::CODE_W'(i + 1);
            end
        end
    end

    assign is_note = (code >= ktg_pkg::KEY_NOTE_FIRST) && (code <= ktg_pkg::KEY_NOTE_LAST);
    assign is_oct  = (code >= ktg_pkg::KEY_OCT_FIRST) && (code <= ktg_pkg::KEY_OCT_LAST);

    assign o_stat.need_div = i_command && is_note && (code != r_last);
    assign o_stat.div_last = (r_cnt == CW'(TW - 1));

    assign tick_inc = r_tick + 1'b1;
    assign rem_sh   = {r_rem, r_dvd[TW-1]};
    assign ge       = (rem_sh >= {1'b0, r_divisor});

    always_comb begin
        n_oct     = r_oct;
        n_freq    = r_freq;
        n_half    = r_half;
        n_tick    = r_tick;
        n_phase   = r_phase;
        n_tone_on = r_tone_on;
        n_last    = r_last;
        n_divisor = r_divisor;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_dvd     = r_dvd;
        n_cnt     = r_cnt;

        if (i_cmd.apply) begin
            if (!i_command) begin
                n_tick = tick_inc;
                if (tick_inc >= r_half) begin
                    n_tick  = '0;
                    n_phase = !r_phase;
                end
            end else begin
                if (is_note) begin
                    n_freq = ktg_pkg::note_freq(3'(code - ktg_pkg::KEY_NOTE_FIRST), r_oct);
                end else if (is_oct) begin
                    n_oct = ktg_pkg::OCT_W'(code - ktg_pkg::KEY_OCT_FIRST);
                end
                if (code != r_last) begin
                    n_last = code;
                    if (!is_note) begin
                        n_tone_on = 1'b0;
                    end
                end
                // divider setup; only used when a new note is decoded
                n_divisor = DW'(n_freq) << ktg_pkg::WAVE_SHIFT;
                n_rem     = '0;
                n_quo     = '0;
                n_dvd     = DIVIDEND;
                n_cnt     = '0;
            end
        end

        if (i_cmd.div_step) begin
            n_rem = ge ? DW'(rem_sh - {1'b0, r_divisor}) : DW'(rem_sh);
            n_quo = {r_quo[TW-2:0], ge};
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt + 1'b1;
            if (o_stat.div_last) begin
                n_half    = (|n_quo[TW-1:HW]) ? ktg_pkg::HALF_MAX : n_quo[HW-1:0];
                n_tone_on = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct     <= ktg_pkg::OCT_RST;
            r_freq    <= ktg_pkg::FREQ_RST;
            r_half    <= HALF_RST;
            r_tick    <= '0;
            r_phase   <= 1'b0;
            r_tone_on <= 1'b0;
            r_last    <= ktg_pkg::KEY_NONE;
        end else begin
            r_oct     <= n_oct;
            r_freq    <= n_freq;
            r_half    <= n_half;
            r_tick    <= n_tick;
            r_phase   <= n_phase;
            r_tone_on <= n_tone_on;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvd     <= n_dvd;
        r_cnt     <= n_cnt;
    end

    // result taken from the updated state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_dac_sample    <= (n_tone_on && n_phase) ? ktg_pkg::DAC_HIGH : ktg_pkg::DAC_LOW;
            o_note_index    <= ((n_last >= ktg_pkg::KEY_NOTE_FIRST) &&
                                (n_last <= ktg_pkg::KEY_NOTE_LAST)) ? n_last[2:0] : 3'd0;
            o_octave_number <= n_oct + 1'b1;
            o_sounding      <= n_tone_on;
        end
    end

endmodule
